/* rtl/core/msrr_pkg.sv */
`timescale 1ns / 1ps

package msrr_pkg;

    // command codes on the func field
    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_REGULATE = 2'd1;
    localparam logic [1:0] FUNC_FORCE    = 2'd2;

    // direction codes, the fourth code reads as stopped
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;
    localparam logic [1:0] DIR_BAD  = 2'd3;

    // configuration register indexes
    localparam logic CFG_STEP_SIZE   = 1'b0;
    localparam logic CFG_FLOOR_SPEED = 1'b1;

    localparam int FUNC_W = 2;
    localparam int DIR_W  = 2;

    function automatic logic [1:0] norm_dir(input logic [1:0] d);
        norm_dir = (d == DIR_BAD) ? DIR_STOP : d;
    endfunction

endpackage

/* rtl/core/msrr_cfg.sv */
`timescale 1ns / 1ps

module msrr_cfg #(
    parameter int SPEED_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [SPEED_BITS-1:0] cfg_wdata,
    output logic [SPEED_BITS-1:0] step_size,
    output logic [SPEED_BITS-1:0] eff_min
);

    logic [SPEED_BITS-1:0] step_reg;
    logic [SPEED_BITS-1:0] min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= SPEED_BITS'(1);
            min_reg  <= SPEED_BITS'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_addr == msrr_pkg::CFG_STEP_SIZE)
                step_reg <= cfg_wdata;
            else
                min_reg <= cfg_wdata;
        end
    end

    assign step_size = step_reg;
    // running minimum never drops below one step
    assign eff_min   = (min_reg < step_reg) ? step_reg : min_reg;

endmodule

/* rtl/core/msrr_step.sv */
`timescale 1ns / 1ps

module msrr_step #(
    parameter int SPEED_BITS = 16
) (
    input  logic [1:0]            func,
    input  logic [SPEED_BITS-1:0] speed,
    input  logic [1:0]            direction,
    input  logic [SPEED_BITS-1:0] step_size,
    input  logic [SPEED_BITS-1:0] eff_min,
    input  logic [SPEED_BITS-1:0] cur_speed,
    input  logic [1:0]            cur_dir,
    input  logic [SPEED_BITS-1:0] tgt_speed,
    input  logic [1:0]            tgt_dir,
    output logic [SPEED_BITS-1:0] cur_speed_next,
    output logic [1:0]            cur_dir_next,
    output logic [SPEED_BITS-1:0] tgt_speed_next,
    output logic [1:0]            tgt_dir_next,
    output logic                  update
);

    logic [1:0]            dir_n;
    logic [SPEED_BITS-1:0] up_gap;
    logic [SPEED_BITS-1:0] down_gap;
    logic [SPEED_BITS-1:0] reg_speed;

    assign dir_n    = msrr_pkg::norm_dir(direction);
    assign up_gap   = tgt_speed - cur_speed;
    assign down_gap = cur_speed - tgt_speed;

    always_comb
    begin
        cur_speed_next = cur_speed;
        cur_dir_next   = cur_dir;
        tgt_speed_next = tgt_speed;
        tgt_dir_next   = tgt_dir;
        update         = 1'b0;
        reg_speed      = speed;

        case (func)
            msrr_pkg::FUNC_TICK:
            begin
                if (!(cur_speed == tgt_speed && cur_dir == tgt_dir))
                begin
                    update = 1'b1;
                    if (cur_dir != msrr_pkg::DIR_STOP && cur_dir != tgt_dir)
                    begin
                        // reversing: slow down to the minimum first
                        if (cur_speed <= eff_min)
                        begin
                            cur_speed_next = (tgt_dir == msrr_pkg::DIR_STOP) ?
                                             '0 : eff_min;
                            cur_dir_next   = tgt_dir;
                        end
                        else
                            cur_speed_next = cur_speed - step_size;
                    end
                    else
                    begin
                        cur_dir_next = tgt_dir;
                        if (cur_speed < tgt_speed)
                            cur_speed_next = (up_gap < step_size) ?
                                             tgt_speed : cur_speed + step_size;
                        else
                            cur_speed_next = (down_gap < step_size) ?
                                             tgt_speed : cur_speed - step_size;
                    end
                end
            end
            msrr_pkg::FUNC_REGULATE:
            begin
                if (dir_n == msrr_pkg::DIR_STOP)
                    reg_speed = '0;
                else if (speed < eff_min)
                    reg_speed = eff_min;
                tgt_speed_next = reg_speed;
                tgt_dir_next   = dir_n;
                if (cur_dir == msrr_pkg::DIR_STOP)
                begin
                    cur_speed_next = (dir_n == msrr_pkg::DIR_STOP) ? '0 : eff_min;
                    cur_dir_next   = dir_n;
                    update         = 1'b1;
                end
            end
            msrr_pkg::FUNC_FORCE:
            begin
                tgt_speed_next = speed;
                cur_speed_next = speed;
                tgt_dir_next   = dir_n;
                cur_dir_next   = dir_n;
                update         = 1'b1;
            end
            default:
            begin
                update = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/motor_speed_ramp_reversal_top.sv */
`timescale 1ns / 1ps

// Ramps one motor toward a commanded speed and direction. Each input item is a
// tick, a regulate or a force command; each yields exactly one result item with
// the speed and direction now applied and a flag telling whether the driver was
// written. One item is taken every cycle unless m_tready stalls the output; an
// accepted item sits in the input register, and the state and the result
// register are updated together when it moves on. Each item reads the speed
// state and writes it back before the next item uses it. Configuration
// (step_size index 0, floor speed index 1) must be written by the user only
// while no item is in flight; the block itself does not enforce it.
module motor_speed_ramp_reversal_top #(
    parameter int SPEED_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // func, speed, direction (lowest bit up), zero padded
    input  logic [(msrr_pkg::FUNC_W + SPEED_BITS + msrr_pkg::DIR_W + 7) / 8 * 8 - 1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // drive_speed, drive_direction (lowest bit up), zero padded
    output logic [(SPEED_BITS + msrr_pkg::DIR_W + 7) / 8 * 8 - 1:0] m_tdata,
    // drive_update
    output logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [SPEED_BITS-1:0] cfg_wdata
);

    localparam int OUT_BITS = SPEED_BITS + msrr_pkg::DIR_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    logic                  in_valid_reg;
    logic [1:0]            in_func_reg;
    logic [SPEED_BITS-1:0] in_speed_reg;
    logic [1:0]            in_dir_reg;

    logic                  out_valid_reg;
    logic                  out_upd_reg;

    logic [SPEED_BITS-1:0] cur_speed_reg, cur_speed_next;
    logic [1:0]            cur_dir_reg, cur_dir_next;
    logic [SPEED_BITS-1:0] tgt_speed_reg, tgt_speed_next;
    logic [1:0]            tgt_dir_reg, tgt_dir_next;
    logic                  upd_next;

    logic [SPEED_BITS-1:0] step_size;
    logic [SPEED_BITS-1:0] eff_min;

    logic advance;
    logic fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    msrr_cfg #(
        .SPEED_BITS (SPEED_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step_size (step_size),
        .eff_min   (eff_min)
    );

    msrr_step #(
        .SPEED_BITS (SPEED_BITS)
    ) u_step (
        .func           (in_func_reg),
        .speed          (in_speed_reg),
        .direction      (in_dir_reg),
        .step_size      (step_size),
        .eff_min        (eff_min),
        .cur_speed      (cur_speed_reg),
        .cur_dir        (cur_dir_reg),
        .tgt_speed      (tgt_speed_reg),
        .tgt_dir        (tgt_dir_reg),
        .cur_speed_next (cur_speed_next),
        .cur_dir_next   (cur_dir_next),
        .tgt_speed_next (tgt_speed_next),
        .tgt_dir_next   (tgt_dir_next),
        .update         (upd_next)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg  <= s_tdata[msrr_pkg::FUNC_W-1:0];
            in_speed_reg <= s_tdata[msrr_pkg::FUNC_W +: SPEED_BITS];
            in_dir_reg   <= s_tdata[msrr_pkg::FUNC_W + SPEED_BITS +: msrr_pkg::DIR_W];
        end
    end

    // motor state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_speed_reg <= '0;
            cur_dir_reg   <= msrr_pkg::DIR_STOP;
            tgt_speed_reg <= '0;
            tgt_dir_reg   <= msrr_pkg::DIR_STOP;
        end
        else
        begin
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
            begin
                cur_speed_reg <= cur_speed_next;
                cur_dir_reg   <= cur_dir_next;
                tgt_speed_reg <= tgt_speed_next;
                tgt_dir_reg   <= tgt_dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_upd_reg <= upd_next;
    end

    // the result fields are the state itself after the item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({cur_dir_reg, cur_speed_reg});
    assign m_tuser  = out_upd_reg;

    a_dir_legal : assert property (@(posedge clk) disable iff (!rst_n)
        cur_dir_reg != msrr_pkg::DIR_BAD && tgt_dir_reg != msrr_pkg::DIR_BAD)
        else $error("direction state holds the unused code");

    a_stall_src : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    a_no_update_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !upd_next) |=> ($stable(cur_speed_reg) && $stable(cur_dir_reg)))
        else $error("drive setting changed on an item flagged as no update");

endmodule

/* test/tb_motor_speed_ramp_reversal_top.sv */
`timescale 1ns / 1ps

module tb_motor_speed_ramp_reversal_top;

    localparam int IN_W = 24;
    localparam int OUT_W = 24;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 215;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] spd;
        logic [1:0]  dir;
    } motor_cmd_t;

    typedef struct packed {
        logic [15:0] spd;
        logic [1:0]  dir;
        logic        upd;
    } drive_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic cfg_addr = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // ramp state and register copies
    logic [15:0] cur_spd = '0;
    logic [1:0]  cur_dir = msrr_pkg::DIR_STOP;
    logic [15:0] tgt_spd = '0;
    logic [1:0]  tgt_dir = msrr_pkg::DIR_STOP;
    logic [15:0] cfg_step = 16'd1;
    logic [15:0] cfg_min = 16'd1;

    motor_cmd_t cmd_q[$];
    drive_t     drive_q[$];

    bit in_taken = 1'b0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;
    bit hold_request = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int mismatches = 0;
    int cycles = 0;

    motor_speed_ramp_reversal_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic logic [15:0] eff_min();
        return (cfg_min < cfg_step) ? cfg_step : cfg_min;
    endfunction

    // advances the ramp state by one command and returns the driver setting
    function automatic drive_t apply_command(motor_cmd_t c);
        drive_t r;
        logic [1:0] d;
        logic [15:0] mn;
        mn = eff_min();
        d = (c.dir == msrr_pkg::DIR_BAD) ? msrr_pkg::DIR_STOP : c.dir;
        r.upd = 1'b0;
        case (c.func)
            msrr_pkg::FUNC_TICK:
            begin
                if (cur_spd != tgt_spd || cur_dir != tgt_dir)
                begin
                    r.upd = 1'b1;
                    if (cur_dir != msrr_pkg::DIR_STOP && cur_dir != tgt_dir)
                    begin
                        // reversal: slow to the minimum before switching
                        if (cur_spd <= mn)
                        begin
                            cur_spd = (tgt_dir == msrr_pkg::DIR_STOP) ? 16'd0 : mn;
                            cur_dir = tgt_dir;
                        end
                        else
                            cur_spd = cur_spd - cfg_step;
                    end
                    else
                    begin
                        cur_dir = tgt_dir;
                        if (cur_spd < tgt_spd)
                            cur_spd = (tgt_spd - cur_spd < cfg_step) ? tgt_spd
                                                                    : cur_spd + cfg_step;
                        else
                            cur_spd = (cur_spd - tgt_spd < cfg_step) ? tgt_spd
                                                                    : cur_spd - cfg_step;
                    end
                end
            end
            msrr_pkg::FUNC_REGULATE:
            begin
                if (d == msrr_pkg::DIR_STOP)
                    tgt_spd = 16'd0;
                else
                    tgt_spd = (c.spd < mn) ? mn : c.spd;
                tgt_dir = d;
                if (cur_dir == msrr_pkg::DIR_STOP)
                begin
                    cur_spd = (d == msrr_pkg::DIR_STOP) ? 16'd0 : mn;
                    cur_dir = d;
                    r.upd = 1'b1;
                end
            end
            msrr_pkg::FUNC_FORCE:
            begin
                tgt_spd = c.spd;
                cur_spd = c.spd;
                tgt_dir = d;
                cur_dir = d;
                r.upd = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.spd = cur_spd;
        r.dir = cur_dir;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_speed();
        logic [15:0] mn;
        mn = eff_min();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return mn + 16'($urandom_range(0, 2)) - 16'd1;
            3: return 16'($urandom_range(0, 4 * int'(mn)));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [1:0] pick_dir();
        case ($urandom_range(0, 9))
            0, 1: return msrr_pkg::DIR_STOP;
            2: return msrr_pkg::DIR_BAD;
            3, 4, 5: return msrr_pkg::DIR_BWD;
            default: return msrr_pkg::DIR_FWD;
        endcase
    endfunction

    task automatic push_cmd(logic [1:0] func, logic [15:0] spd, logic [1:0] dir);
        motor_cmd_t c;
        c.func = func;
        c.spd = spd;
        c.dir = dir;
        cmd_q.push_back(c);
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_cmd(msrr_pkg::FUNC_TICK, 16'($urandom()), 2'($urandom()));
    endtask

    // random commands, mostly a regulate or force followed by a run of ticks
    task automatic add_random(int n);
        int count;
        int r;
        int k;
        count = 0;
        while (count < n)
        begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 25);
            if (r < 40)
            begin
                push_cmd(msrr_pkg::FUNC_REGULATE, pick_speed(), pick_dir());
                push_ticks(k);
                count += k + 1;
            end
            else if (r < 55)
            begin
                push_cmd(msrr_pkg::FUNC_FORCE, pick_speed(), pick_dir());
                push_ticks(k / 2);
                count += k / 2 + 1;
            end
            else if (r < 62)
            begin
                push_cmd(FUNC_NONE, 16'($urandom()), 2'($urandom()));
                count++;
            end
            else
            begin
                push_ticks(1);
                count++;
            end
        end
    endtask

    task automatic write_reg(logic addr, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (addr == msrr_pkg::CFG_STEP_SIZE)
            cfg_step = val;
        else
            cfg_min = val;
    endtask

    task automatic wait_idle();
        while (cmd_q.size() != 0 || s_tvalid || drive_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(logic [15:0] step, logic [15:0] mn, bit steady, bit squeeze);
        wait_idle();
        write_reg(msrr_pkg::CFG_STEP_SIZE, step);
        write_reg(msrr_pkg::CFG_FLOOR_SPEED, mn);
        send_steady = steady || squeeze;
        recv_steady = steady;
        hold_request = squeeze;
        add_random(ITEMS_PER_PHASE);
    endtask

    // sender
    always @(negedge clk)
    begin : drive_inputs
        motor_cmd_t c;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (send_gap > 0 || cmd_q.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                c = cmd_q.pop_front();
                s_tdata <= {4'b0, c.dir, c.spd, c.func};
                s_tvalid <= 1'b1;
                send_gap = pick_gap(send_steady);
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap = pick_gap(recv_steady);
            end
        end
    end

    // predict on each accepted command, compare each accepted result
    always @(posedge clk)
    begin : monitor
        motor_cmd_t c;
        drive_t want;
        drive_t got;
        if (rst_n)
        begin
            in_taken = s_tvalid && s_tready;
            if (in_taken)
            begin
                c.func = s_tdata[1:0];
                c.spd = s_tdata[17:2];
                c.dir = s_tdata[19:18];
                drive_q.push_back(apply_command(c));
            end
            if (m_tvalid && m_tready)
            begin
                got.spd = m_tdata[15:0];
                got.dir = m_tdata[17:16];
                got.upd = m_tuser;
                if (drive_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: speed %0d dir %0d update %0b",
                                 got.spd, got.dir, got.upd);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got.spd !== want.spd || got.dir !== want.dir
                        || got.upd !== want.upd)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at cycle %0d: expected speed %0d dir %0d ",
                                      "update %0b, got speed %0d dir %0d update %0b"},
                                     cycles, want.spd, want.dir, want.upd,
                                     got.spd, got.dir, got.upd);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed commands, effective minimum 1000
        write_reg(msrr_pkg::CFG_STEP_SIZE, 16'd250);
        write_reg(msrr_pkg::CFG_FLOOR_SPEED, 16'd1000);
        // already at target
        push_cmd(msrr_pkg::FUNC_TICK, 16'd0, msrr_pkg::DIR_STOP);
        // start from stop at minimum
        push_cmd(msrr_pkg::FUNC_REGULATE, 16'd0, msrr_pkg::DIR_FWD);
        push_cmd(msrr_pkg::FUNC_REGULATE, 16'hFFFF, msrr_pkg::DIR_FWD);
        push_ticks(2);
        // reversal
        push_cmd(msrr_pkg::FUNC_REGULATE, 16'd1600, msrr_pkg::DIR_BWD);
        push_ticks(4);
        // stop request ramps to zero
        push_cmd(msrr_pkg::FUNC_REGULATE, 16'hFFFF, msrr_pkg::DIR_STOP);
        push_ticks(5);
        // stop while stopped
        push_cmd(msrr_pkg::FUNC_REGULATE, 16'd500, msrr_pkg::DIR_STOP);
        push_cmd(msrr_pkg::FUNC_REGULATE, 16'd500, msrr_pkg::DIR_BAD);
        push_cmd(msrr_pkg::FUNC_FORCE, 16'hFFFF, msrr_pkg::DIR_FWD);
        push_cmd(msrr_pkg::FUNC_FORCE, 16'd1234, msrr_pkg::DIR_BAD);
        push_cmd(FUNC_NONE, 16'hFFFF, msrr_pkg::DIR_BAD);
        push_cmd(msrr_pkg::FUNC_TICK, 16'hFFFF, msrr_pkg::DIR_BAD);
        push_cmd(msrr_pkg::FUNC_FORCE, 16'd0, msrr_pkg::DIR_BWD);
        // below minimum, reversing
        push_cmd(msrr_pkg::FUNC_REGULATE, 16'd999, msrr_pkg::DIR_FWD);
        push_ticks(3);

        run_phase(16'd1, 16'd1, 1'b1, 1'b0);
        run_phase(16'd100, 16'd500, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        run_phase(16'd7, 16'd3, 1'b0, 1'b1);
        run_phase(16'd1, 16'hFFFF, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'd1, 1'b0, 1'b0);
        run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 1'b0, 1'b0);

        wait_idle();
        repeat (8) @(posedge clk);
        if (drive_q.size() != 0)
            $display("%0d expected result items never arrived", drive_q.size());
        if (mismatches == 0 && drive_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
